@@ rtl/core/sgf_pkg.sv @@
// Shared types, constants and register map for the stereo gain/fade/silence-skip block.
`timescale 1ns / 1ps

package sgf_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    localparam int GAIN_W   = 24;
    localparam int LEN_W    = 31;
    localparam int SEC_W    = 8;
    localparam int SPS_W    = 20;
    localparam int THR_W    = 23;
    localparam int CNT_W    = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;
    localparam logic [SPS_W-1:0]  SPS_RESET  = 20'd44100;
    localparam logic [THR_W-1:0]  THR_RESET  = 23'd8;

    localparam int FRAC_BITS = 16;
    localparam int SCALE_W   = 17;
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SKIP,
        S_MUL_L,
        S_WR_L,
        S_MUL_R,
        S_WR_R,
        S_DIV_INIT,
        S_DIV,
        S_FMUL_L,
        S_FWR_L,
        S_FMUL_R,
        S_FWR_R,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic skip_update;
        logic mul_en;
        logic mul_right;
        logic mul_fade;
        logic wr_l;
        logic wr_r;
        logic wr_fade;
        logic div_init;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic armed;
        logic skip_done;
        logic past_end;
        logic fade_on;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/core/sgf_in_if.sv @@
// Input sample channel: valid/ready handshake with stereo payload.
`timescale 1ns / 1ps

interface sgf_in_if #(
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

@@ rtl/core/sgf_out_if.sv @@
// Output sample channel: valid/ready handshake with stereo payload.
`timescale 1ns / 1ps

interface sgf_out_if #(
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

@@ rtl/core/sgf_datapath.sv @@
// Datapath: config registers, silence detector, shared multiplier, serial divider, output register.
`timescale 1ns / 1ps

module sgf_datapath #(
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sgf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]      i_in_left,
    input  logic signed [SAMPLE_BITS-1:0]      i_in_right,
    input  sgf_pkg::t_dp_cmd                   i_cmd,
    output sgf_pkg::t_dp_status                o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_out_left,
    output logic signed [SAMPLE_BITS-1:0]      o_out_right
);

    localparam int SB   = SAMPLE_BITS;
    localparam int GW   = sgf_pkg::GAIN_W;
    localparam int PW   = SB + GW + 1;
    localparam int DW   = SB + 1;
    localparam int TW   = sgf_pkg::THR_W;
    localparam int CMPW = (DW > TW) ? DW : TW;
    localparam int LW   = sgf_pkg::LEN_W;
    localparam int CW   = sgf_pkg::CNT_W;
    localparam int PSW  = sgf_pkg::SPS_W;
    localparam int SW   = sgf_pkg::SEC_W;
    localparam int QW   = sgf_pkg::SCALE_W;

    // configuration
    logic [GW-1:0]  r_gain;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  r_fade;
    logic           r_forever;
    logic [SW-1:0]  r_skip_sec;
    logic [PSW-1:0] r_sps;
    logic [TW-1:0]  r_thr;

    // skip state
    logic                 r_armed;
    logic [PSW-1:0]       r_sis;
    logic [SW-1:0]        r_ssec;
    logic signed [SB-1:0] r_last_l;
    logic signed [SB-1:0] r_last_r;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    // working registers
    logic signed [SB-1:0] r_l;
    logic signed [SB-1:0] r_r;
    logic signed [SB-1:0] r_ol;
    logic signed [SB-1:0] r_or;
    logic signed [PW-1:0] r_prod;
    logic [LW-1:0]        r_rem;
    logic                 r_dbit;
    logic [QW-1:0]        r_scale;

    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_l;
    logic signed [SB-1:0] r_out_r;

    // silence detection
    logic signed [DW-1:0] diff_l, diff_r;
    logic [DW-1:0]        du_l, du_r, abs_l, abs_r;
    logic                 silent;
    logic [PSW-1:0]       sps_eff;
    logic [PSW:0]         sis_inc;
    logic                 wrap;
    logic [PSW:0]         sis_wrapped;
    logic [PSW-1:0]       n_sis;
    logic [SW-1:0]        ssec_inc;
    logic                 sec_done;
    logic                 skip_done;

    assign diff_l = $signed({r_l[SB-1], r_l}) - $signed({r_last_l[SB-1], r_last_l});
    assign diff_r = $signed({r_r[SB-1], r_r}) - $signed({r_last_r[SB-1], r_last_r});
    assign du_l   = diff_l;
    assign du_r   = diff_r;
    assign abs_l  = du_l[DW-1] ? (~du_l + DW'(1)) : du_l;
    assign abs_r  = du_r[DW-1] ? (~du_r + DW'(1)) : du_r;
    assign silent = (CMPW'(abs_l) <= CMPW'(r_thr)) && (CMPW'(abs_r) <= CMPW'(r_thr));

    assign sps_eff     = (r_sps == '0) ? PSW'(1) : r_sps;
    assign sis_inc     = {1'b0, r_sis} + (PSW+1)'(1);
    assign wrap        = sis_inc >= {1'b0, sps_eff};
    assign sis_wrapped = sis_inc - {1'b0, sps_eff};
    assign n_sis       = wrap ? sis_wrapped[PSW-1:0] : sis_inc[PSW-1:0];
    assign ssec_inc    = (r_ssec != '1) ? (r_ssec + SW'(1)) : r_ssec;
    assign sec_done    = wrap && (ssec_inc >= r_skip_sec);
    assign skip_done   = !silent || sec_done;

    // track position
    logic [CW-1:0] total;
    logic [CW-1:0] remain;
    logic          past_end;
    logic          fade_on;

    assign total    = {1'b0, r_len} + {1'b0, r_fade};
    assign remain   = total - r_cnt;
    assign past_end = !r_forever && (r_cnt >= total);
    assign fade_on  = !r_forever && (r_fade != '0) && (r_cnt >= {1'b0, r_len});
    assign n_cnt    = (r_cnt != '1) ? (r_cnt + CW'(1)) : r_cnt;

    // divider step: quotient bit per cycle, remainder stays below fade
    logic [CW-1:0] trial;
    logic [CW-1:0] fade_ext;
    logic [CW-1:0] trial_sub;
    logic          trial_ge;

    assign trial     = {r_rem, r_dbit};
    assign fade_ext  = {1'b0, r_fade};
    assign trial_ge  = trial >= fade_ext;
    assign trial_sub = trial - fade_ext;

    // shared multiplier
    logic signed [SB-1:0] mul_a;
    logic [GW-1:0]        mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod_sh;
    logic                 ovf;
    logic signed [SB-1:0] clamped;
    logic signed [SB-1:0] wr_val;

    always_comb begin
        if (i_cmd.mul_fade) begin
            mul_a = i_cmd.mul_right ? r_or : r_ol;
            mul_b = GW'(r_scale);
        end else begin
            mul_a = i_cmd.mul_right ? r_r : r_l;
            mul_b = r_gain;
        end
    end

    assign mul_p   = mul_a * $signed({1'b0, mul_b});
    assign prod_sh = r_prod >>> sgf_pkg::FRAC_BITS;
    assign ovf     = prod_sh[PW-1:SB-1] != {(PW-SB+1){prod_sh[PW-1]}};

    always_comb begin
        if (!ovf) begin
            clamped = prod_sh[SB-1:0];
        end else if (prod_sh[PW-1]) begin
            clamped = {1'b1, {(SB-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // faded value always fits since scale never exceeds unity
    assign wr_val = i_cmd.wr_fade ? prod_sh[SB-1:0] : clamped;

    // configuration and skip state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= sgf_pkg::GAIN_RESET;
            r_len      <= '0;
            r_fade     <= '0;
            r_forever  <= 1'b0;
            r_skip_sec <= '0;
            r_sps      <= sgf_pkg::SPS_RESET;
            r_thr      <= sgf_pkg::THR_RESET;
            r_armed    <= 1'b0;
            r_sis      <= '0;
            r_ssec     <= '0;
            r_last_l   <= '0;
            r_last_r   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgf_pkg::CFG_GAIN:    r_gain    <= i_cfg_data[GW-1:0];
                sgf_pkg::CFG_LENGTH:  r_len     <= i_cfg_data[LW-1:0];
                sgf_pkg::CFG_FADE:    r_fade    <= i_cfg_data[LW-1:0];
                sgf_pkg::CFG_FOREVER: r_forever <= i_cfg_data[0];
                sgf_pkg::CFG_SKIP: begin
                    r_skip_sec <= i_cfg_data[SW-1:0];
                    r_armed    <= i_cfg_data[SW-1:0] != '0;
                    r_sis      <= '0;
                    r_ssec     <= '0;
                end
                sgf_pkg::CFG_SPS:     r_sps     <= i_cfg_data[PSW-1:0];
                sgf_pkg::CFG_THRESH:  r_thr     <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end else if (i_cmd.skip_update && r_armed) begin
            r_last_l <= r_l;
            r_last_r <= r_r;
            if (silent) begin
                r_sis <= n_sis;
                if (wrap) begin
                    r_ssec <= sec_done ? '0 : ssec_inc;
                end
            end else begin
                r_sis  <= '0;
                r_ssec <= '0;
            end
            if (skip_done) begin
                r_armed <= 1'b0;
            end
        end
    end

    // emitted count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cnt       <= n_cnt;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_l <= r_ol;
            r_out_r <= r_or;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_l <= i_in_left;
            r_r <= i_in_right;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.wr_l) begin
            r_ol <= wr_val;
        end
        if (i_cmd.wr_r) begin
            r_or <= wr_val;
        end
        if (i_cmd.div_init) begin
            r_rem   <= remain[CW-1:1];
            r_dbit  <= remain[0];
            r_scale <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= trial_ge ? trial_sub[LW-1:0] : trial[LW-1:0];
            r_dbit  <= 1'b0;
            r_scale <= {r_scale[QW-2:0], trial_ge};
        end
    end

    assign o_status.armed     = r_armed;
    assign o_status.skip_done = skip_done;
    assign o_status.past_end  = past_end;
    assign o_status.fade_on   = fade_on;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

endmodule

@@ rtl/core/sgf_ctrl.sv @@
// Controller: sequences one sample transaction through skip, gain, fade and emit steps.
`timescale 1ns / 1ps

module sgf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sgf_pkg::t_dp_status i_status,
    output sgf_pkg::t_dp_cmd    o_cmd
);

    localparam int NW = sgf_pkg::DIV_CNT_W;

    sgf_pkg::t_state r_state;
    sgf_pkg::t_state n_state;
    logic [NW-1:0]   r_div_cnt;
    logic            div_last;

    assign div_last = r_div_cnt == NW'(sgf_pkg::DIV_STEPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (o_cmd.div_init) begin
            r_div_cnt <= '0;
        end else if (o_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + NW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgf_pkg::S_IDLE:     if (i_in_valid) n_state = sgf_pkg::S_SKIP;
            sgf_pkg::S_SKIP: begin
                // silent sample still being skipped, or track over: drop it
                if ((i_status.armed && !i_status.skip_done) || i_status.past_end) begin
                    n_state = sgf_pkg::S_IDLE;
                end else begin
                    n_state = sgf_pkg::S_MUL_L;
                end
            end
            sgf_pkg::S_MUL_L:    n_state = sgf_pkg::S_WR_L;
            sgf_pkg::S_WR_L:     n_state = sgf_pkg::S_MUL_R;
            sgf_pkg::S_MUL_R:    n_state = sgf_pkg::S_WR_R;
            sgf_pkg::S_WR_R:     n_state = i_status.fade_on ? sgf_pkg::S_DIV_INIT
                                                           : sgf_pkg::S_EMIT;
            sgf_pkg::S_DIV_INIT: n_state = sgf_pkg::S_DIV;
            sgf_pkg::S_DIV:      if (div_last) n_state = sgf_pkg::S_FMUL_L;
            sgf_pkg::S_FMUL_L:   n_state = sgf_pkg::S_FWR_L;
            sgf_pkg::S_FWR_L:    n_state = sgf_pkg::S_FMUL_R;
            sgf_pkg::S_FMUL_R:   n_state = sgf_pkg::S_FWR_R;
            sgf_pkg::S_FWR_R:    n_state = sgf_pkg::S_EMIT;
            sgf_pkg::S_EMIT:     if (i_status.out_free) n_state = sgf_pkg::S_IDLE;
            default:             n_state = sgf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sgf_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            sgf_pkg::S_SKIP:     o_cmd.skip_update = 1'b1;
            sgf_pkg::S_MUL_L:    o_cmd.mul_en = 1'b1;
            sgf_pkg::S_WR_L:     o_cmd.wr_l = 1'b1;
            sgf_pkg::S_MUL_R: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_right = 1'b1;
            end
            sgf_pkg::S_WR_R:     o_cmd.wr_r = 1'b1;
            sgf_pkg::S_DIV_INIT: o_cmd.div_init = 1'b1;
            sgf_pkg::S_DIV:      o_cmd.div_step = 1'b1;
            sgf_pkg::S_FMUL_L: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_fade = 1'b1;
            end
            sgf_pkg::S_FWR_L: begin
                o_cmd.wr_l    = 1'b1;
                o_cmd.wr_fade = 1'b1;
            end
            sgf_pkg::S_FMUL_R: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_fade  = 1'b1;
                o_cmd.mul_right = 1'b1;
            end
            sgf_pkg::S_FWR_R: begin
                o_cmd.wr_r    = 1'b1;
                o_cmd.wr_fade = 1'b1;
            end
            sgf_pkg::S_EMIT:     o_cmd.emit = i_status.out_free;
            default: ;
        endcase
    end

endmodule

@@ rtl/core/stereo_gain_fade_silence_skip_top.sv @@
// Stereo gain, clamp, fade-out and leading-silence skip: top level.
// Each accepted sample passes through the skip check and the left and right gain multiplies and writes;
// inside the fade, a 17-step serial divider for the fade scale and the fade multiplies follow, then emit.
// A new sample is taken only after the last one is emitted or dropped; output backpressure stalls emit.
// Synchronous active-low reset restores register defaults and clears emitted count,
// skip state and output valid.
`timescale 1ns / 1ps

module stereo_gain_fade_silence_skip_top #(
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sgf_in_if.sink                         i_in,
    sgf_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sgf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sgf_pkg::t_dp_cmd    cmd;
    sgf_pkg::t_dp_status status;
    logic                in_ready;
    logic                out_valid;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    sgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_left   (i_in.in_left),
        .i_in_right  (i_in.in_right),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_left  (out_left),
        .o_out_right (out_right)
    );

    assign i_in.ready      = in_ready;
    assign o_out.valid     = out_valid;
    assign o_out.out_left  = out_left;
    assign o_out.out_right = out_right;

    // output register is only loaded when it is empty or being drained
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register busy");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a transaction is in flight");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_in, cmd.skip_update, cmd.mul_en, cmd.wr_l, cmd.wr_r,
                  cmd.div_init, cmd.div_step, cmd.emit}))
        else $error("more than one datapath action in a cycle");

    a_div_in_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step || cmd.div_init) |-> status.fade_on)
        else $error("fade divider running outside the fade region");

endmodule
